### hw/rtl/ppm_receiver_with_arm_gesture_macros.svh
// Assertion macros shared by the PPM receiver RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef PPM_RECEIVER_WITH_ARM_GESTURE_MACROS_SVH
`define PPM_RECEIVER_WITH_ARM_GESTURE_MACROS_SVH

// Same-cycle implication.
`define PPMRX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PPMRX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ppmrx_pkg.sv
// Package for the PPM receiver: widths, reset values, codes and the zone helper.
// No dependencies.
`timescale 1ns / 1ps

package ppmrx_pkg;

  localparam int NUM_CH = 6;
  localparam int IDX_W  = 3;
  localparam int CFG_IDX_W = 3;

  typedef logic [15:0] width_t;
  typedef width_t [NUM_CH-1:0] chan_arr_t;

  // edge item handed from the input register to the frame decoder
  typedef struct packed {
    logic   fire;
    width_t stamp;
    logic   rising;
  } edge_req_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_YAW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_PITCH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROLL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 3'd4;

  // register reset values
  localparam width_t SYNC_MIN_RST = 16'd2500;
  localparam width_t CENTER_RST   = 16'd1500;
  localparam width_t HOLD_RST     = 16'd500;

  localparam width_t CENTER_OFFSET = 16'd1500;
  localparam width_t CHAN_RST      = 16'd1000;
  localparam width_t STICK_LOW     = 16'd1200;

  // decoder phases
  localparam logic [1:0] PH_SYNC_START = 2'd0;
  localparam logic [1:0] PH_SYNC_END   = 2'd1;
  localparam logic [1:0] PH_CHAN_END   = 2'd2;
  localparam logic [1:0] PH_CHAN_START = 2'd3;

  // zone thresholds
  localparam width_t ZONE_LOW     = 16'd1150;
  localparam width_t ZONE_MID_LO  = 16'd1350;
  localparam width_t ZONE_MID_HI  = 16'd1650;
  localparam width_t ZONE_HIGH    = 16'd1850;

  localparam logic [1:0] ZONE_NONE = 2'd0;
  localparam logic [1:0] ZONE_LO   = 2'd1;
  localparam logic [1:0] ZONE_MID  = 2'd2;
  localparam logic [1:0] ZONE_HI   = 2'd3;

  // gesture codes
  localparam logic [7:0] CODE_RESTART = 8'd0;
  localparam logic [7:0] CODE_LOCK    = 8'd165;
  localparam logic [7:0] CODE_UNLOCK  = 8'd167;
  localparam logic [7:0] CODE_KEEP_A  = 8'd149;
  localparam logic [7:0] CODE_KEEP_B  = 8'd150;
  localparam logic [7:0] CODE_KEEP_C  = 8'd151;
  localparam logic [7:0] CODE_KEEP_D  = 8'd181;
  localparam logic [7:0] CODE_KEEP_E  = 8'd182;
  localparam logic [7:0] CODE_KEEP_F  = 8'd183;

  function automatic logic [1:0] zone_of(input width_t w);
    logic [1:0] z;
    z = ZONE_NONE;
    if (w < ZONE_LOW) begin
      z = ZONE_LO;
    end else if (w > ZONE_MID_LO && w < ZONE_MID_HI) begin
      z = ZONE_MID;
    end else if (w > ZONE_HIGH) begin
      z = ZONE_HI;
    end
    return z;
  endfunction

endpackage

### hw/rtl/ppmrx_frame.sv
// PPM frame decoder: sync timing phase machine and the six channel widths.
// Depends on ppmrx_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "ppm_receiver_with_arm_gesture_macros.svh"

module ppmrx_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ppmrx_pkg::edge_req_t req,
  input  ppmrx_pkg::width_t    sync_min,
  output ppmrx_pkg::chan_arr_t widths_o,
  output ppmrx_pkg::chan_arr_t widths_nxt_o,
  output logic                 done_o
);

  logic [1:0]                  phase_r, phase_nxt;
  logic                        exp_rise_r, exp_rise_nxt;
  ppmrx_pkg::width_t           ref_r, ref_nxt;
  logic [ppmrx_pkg::IDX_W-1:0] idx_r, idx_nxt, idx_eff;
  ppmrx_pkg::chan_arr_t        width_r, width_nxt;
  ppmrx_pkg::width_t           diff;
  logic                        done;

  assign diff = req.stamp - ref_r;
  assign idx_eff = (idx_r >= ppmrx_pkg::IDX_W'(ppmrx_pkg::NUM_CH)) ? '0 : idx_r;

  always_comb begin
    phase_nxt    = phase_r;
    exp_rise_nxt = exp_rise_r;
    ref_nxt      = ref_r;
    idx_nxt      = idx_r;
    width_nxt    = width_r;
    done         = 1'b0;
    if (req.fire && (req.rising == exp_rise_r)) begin
      case (phase_r)
        ppmrx_pkg::PH_SYNC_START: begin
          ref_nxt      = req.stamp;
          exp_rise_nxt = 1'b0;
          phase_nxt    = ppmrx_pkg::PH_SYNC_END;
        end
        ppmrx_pkg::PH_SYNC_END: begin
          ref_nxt      = req.stamp;
          exp_rise_nxt = 1'b1;
          phase_nxt    = (diff < sync_min) ? ppmrx_pkg::PH_SYNC_START
                                           : ppmrx_pkg::PH_CHAN_END;
        end
        ppmrx_pkg::PH_CHAN_END: begin
          for (int i = 0; i < ppmrx_pkg::NUM_CH; i++) begin
            if (idx_eff == ppmrx_pkg::IDX_W'(i)) begin
              width_nxt[i] = diff;
            end
          end
          exp_rise_nxt = 1'b0;
          if (idx_eff == ppmrx_pkg::IDX_W'(ppmrx_pkg::NUM_CH - 1)) begin
            idx_nxt   = '0;
            phase_nxt = ppmrx_pkg::PH_SYNC_START;
            done      = 1'b1;
          end else begin
            idx_nxt   = idx_eff + ppmrx_pkg::IDX_W'(1);
            phase_nxt = ppmrx_pkg::PH_CHAN_START;
          end
        end
        ppmrx_pkg::PH_CHAN_START: begin
          ref_nxt      = req.stamp;
          exp_rise_nxt = 1'b1;
          phase_nxt    = ppmrx_pkg::PH_CHAN_END;
        end
        default: begin
          phase_nxt = ppmrx_pkg::PH_SYNC_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= ppmrx_pkg::PH_SYNC_START;
      exp_rise_r <= 1'b1;
      ref_r      <= '0;
      idx_r      <= '0;
      for (int i = 0; i < ppmrx_pkg::NUM_CH; i++) begin
        width_r[i] <= ppmrx_pkg::CHAN_RST;
      end
    end else begin
      phase_r    <= phase_nxt;
      exp_rise_r <= exp_rise_nxt;
      ref_r      <= ref_nxt;
      idx_r      <= idx_nxt;
      width_r    <= width_nxt;
    end
  end

  assign widths_o     = width_r;
  assign widths_nxt_o = width_nxt;
  assign done_o       = done;

  `PPMRX_ASSERT_NEXT(a_done_rewinds, done,
    phase_r == ppmrx_pkg::PH_SYNC_START && idx_r == '0 && !exp_rise_r,
    "frame end did not rewind the decoder")
  `PPMRX_ASSERT_NOW(a_idx_range, 1'b1,
    idx_r < ppmrx_pkg::IDX_W'(ppmrx_pkg::NUM_CH), "channel index out of range")

endmodule

### hw/rtl/ppmrx_gesture.sv
// Stick gesture tracker: zone code, hold counters and the lock flag.
// Depends on ppmrx_pkg.
`timescale 1ns / 1ps

module ppmrx_gesture (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tick,
  input  ppmrx_pkg::chan_arr_t widths,
  input  ppmrx_pkg::width_t    hold_ticks,
  output logic                 lock_nxt_o
);

  logic [7:0]        prev_r, prev_nxt, code, eff_code;
  ppmrx_pkg::width_t lc_r, lc_nxt, uc_r, uc_nxt, lc_tmp, uc_tmp;
  logic              lock_r, lock_nxt;

  assign code = {ppmrx_pkg::zone_of(widths[0]), ppmrx_pkg::zone_of(widths[1]),
                 ppmrx_pkg::zone_of(widths[2]), ppmrx_pkg::zone_of(widths[3])};

  always_comb begin
    prev_nxt = prev_r;
    eff_code = code;
    lc_tmp   = lc_r;
    uc_tmp   = uc_r;
    lc_nxt   = lc_r;
    uc_nxt   = uc_r;
    lock_nxt = lock_r;
    if (tick) begin
      // a fresh code restarts both counts
      if (code != prev_r) begin
        prev_nxt = code;
        eff_code = ppmrx_pkg::CODE_RESTART;
      end
      case (eff_code)
        ppmrx_pkg::CODE_LOCK:   lc_tmp = lc_r + 16'd1;
        ppmrx_pkg::CODE_UNLOCK: uc_tmp = uc_r + 16'd1;
        ppmrx_pkg::CODE_KEEP_A, ppmrx_pkg::CODE_KEEP_B, ppmrx_pkg::CODE_KEEP_C,
        ppmrx_pkg::CODE_KEEP_D, ppmrx_pkg::CODE_KEEP_E, ppmrx_pkg::CODE_KEEP_F: begin
        end
        default: begin
          lc_tmp = '0;
          uc_tmp = '0;
        end
      endcase
      lc_nxt = lc_tmp;
      uc_nxt = uc_tmp;
      if (lc_tmp >= hold_ticks) begin
        lc_nxt   = '0;
        lock_nxt = 1'b1;
      end else if (uc_tmp >= hold_ticks) begin
        uc_nxt   = '0;
        lock_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= ppmrx_pkg::CODE_RESTART;
      lc_r   <= '0;
      uc_r   <= '0;
      lock_r <= 1'b1;
    end else begin
      prev_r <= prev_nxt;
      lc_r   <= lc_nxt;
      uc_r   <= uc_nxt;
      lock_r <= lock_nxt;
    end
  end

  assign lock_nxt_o = lock_nxt;

endmodule

### hw/rtl/ppm_receiver_with_arm_gesture.sv
// Six-channel PPM receiver with arm/disarm stick gestures.
//
// Input channel (in_*): one item per edge or control tick. in_tuser is the
//   item kind (0 capture edge, 1 control tick); in_tdata carries the timer
//   stamp and the edge polarity. Edges of the wrong polarity leave the state
//   as it is but still produce a result.
// Result channel (out_*): exactly one result per input item, in order.
//   out_tlast is high on the result of the edge that stored the sixth channel.
// Config channel (cfg_*): always ready; write only while the block is idle.
// Timing: an accepted item waits in the input register, and its result is
//   registered into the result register when the item advances. Throughput:
//   one item per cycle while out_tready stays high, set by the single update
//   pass from the input register to the result register.
// Stall: while a result waits on out_tready the input register still takes
//   one more item; in_tready drops only when both registers are full.
// Reset (rst_n low, synchronous): registers back to defaults, decoder waits
//   for a rising edge, all channel widths 1000, lock flag set, no items held.
`timescale 1ns / 1ps
`include "ppm_receiver_with_arm_gesture_macros.svh"

module ppm_receiver_with_arm_gesture (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,   // edge_time[15:0], edge_rising[16], zero fill
  input  logic                              in_tuser,   // req_type
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [103:0]                      out_tdata,  // rc_yaw, rc_pitch, rc_altitude, rc_roll,
                                                        // rc_gate, rc_rate (16 each), sticks_ready,
                                                        // locked, zero fill
  output logic                              out_tlast,  // frame_done
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppmrx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                       cfg_data
);

  // configuration registers
  ppmrx_pkg::width_t sync_min_r, c_yaw_r, c_pitch_r, c_roll_r, hold_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_min_r <= ppmrx_pkg::SYNC_MIN_RST;
      c_yaw_r    <= ppmrx_pkg::CENTER_RST;
      c_pitch_r  <= ppmrx_pkg::CENTER_RST;
      c_roll_r   <= ppmrx_pkg::CENTER_RST;
      hold_r     <= ppmrx_pkg::HOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ppmrx_pkg::REG_SYNC_MIN:     sync_min_r <= cfg_data;
        ppmrx_pkg::REG_CENTER_YAW:   c_yaw_r    <= cfg_data;
        ppmrx_pkg::REG_CENTER_PITCH: c_pitch_r  <= cfg_data;
        ppmrx_pkg::REG_CENTER_ROLL:  c_roll_r   <= cfg_data;
        ppmrx_pkg::REG_HOLD_TICKS:   hold_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  logic              in_valid_r;
  logic              in_type_r;
  ppmrx_pkg::width_t in_time_r;
  logic              in_rise_r;
  logic              advance;
  logic              in_take;

  assign advance   = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_type_r <= in_tuser;
      in_time_r <= in_tdata[15:0];
      in_rise_r <= in_tdata[16];
    end
  end

  // update pass: state advances only when the item moves into the result register
  ppmrx_pkg::edge_req_t req;
  ppmrx_pkg::chan_arr_t widths, widths_nxt;
  logic                 done;
  logic                 lock_nxt;

  assign req.fire   = advance && !in_type_r;
  assign req.stamp  = in_time_r;
  assign req.rising = in_rise_r;

  ppmrx_frame u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req),
    .sync_min     (sync_min_r),
    .widths_o     (widths),
    .widths_nxt_o (widths_nxt),
    .done_o       (done)
  );

  // ticks never touch the widths, so the stored ones are current here
  ppmrx_gesture u_gesture (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (advance && in_type_r),
    .widths     (widths),
    .hold_ticks (hold_r),
    .lock_nxt_o (lock_nxt)
  );

  // centred sticks, 16-bit wrap
  ppmrx_pkg::width_t rc_yaw, rc_pitch, rc_roll;
  logic              sticks_ready;

  assign rc_yaw   = widths_nxt[0] - c_yaw_r   + ppmrx_pkg::CENTER_OFFSET;
  assign rc_pitch = widths_nxt[1] - c_pitch_r + ppmrx_pkg::CENTER_OFFSET;
  assign rc_roll  = widths_nxt[3] - c_roll_r  + ppmrx_pkg::CENTER_OFFSET;
  assign sticks_ready = (widths_nxt[2] < ppmrx_pkg::STICK_LOW) &&
                        (widths_nxt[3] < ppmrx_pkg::STICK_LOW);

  // result register
  logic         out_valid_r;
  logic [103:0] out_data_r;
  logic         out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {6'd0, lock_nxt, sticks_ready, widths_nxt[5], widths_nxt[4],
                     rc_roll, widths_nxt[2], rc_pitch, rc_yaw};
      out_last_r <= done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `PPMRX_ASSERT_NEXT(a_hold_item, in_valid_r && !advance,
    in_valid_r && $stable(in_time_r) && $stable(in_type_r),
    "held input item lost or changed")
  `PPMRX_ASSERT_NEXT(a_tick_no_last, advance && in_type_r, !out_tlast,
    "tick item flagged frame end")
  `PPMRX_ASSERT_NEXT(a_result_present, advance, out_tvalid,
    "item advanced without a result")

endmodule

### tb/ppm_receiver_with_arm_gesture_tb.sv
// Self-checking testbench for the six-channel PPM receiver with arm/disarm gestures.
// Drives edge and tick items and register writes, and checks every result against
// a local decoder. Depends on ppmrx_pkg and ppm_receiver_with_arm_gesture.
`timescale 1ns / 1ps

module ppm_receiver_with_arm_gesture_tb;
  import ppmrx_pkg::*;

  // item kinds carried on in_tuser
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // register indexes that the block has no register behind
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_C = 3'd7;

  // one planned input item; a tracking edge takes its polarity and timing from
  // the decoder state at the moment it is put on the bus
  typedef struct {
    logic      kind;
    logic      tracking;
    width_t    stamp;     // absolute time, or lead-in interval when tracking
    logic      rising;
    width_t    sync_w;
    width_t    gap_w;
    chan_arr_t widths;
  } ppm_event_t;

  typedef struct {
    width_t yaw;
    width_t pitch;
    width_t altitude;
    width_t roll;
    width_t gate;
    width_t rate;
    logic   frame_done;
    logic   sticks_ready;
    logic   locked;
  } rc_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata = '0;    // edge_time[15:0], edge_rising[16], zero fill
  logic                 in_tuser = 1'b0;  // req_type
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [103:0]         out_tdata;        // yaw, pitch, altitude, roll, gate, rate,
                                          // sticks_ready[96], locked[97], zero fill
  logic                 out_tlast;        // frame_done
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  ppm_receiver_with_arm_gesture dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ppm_event_t queued_events[$];
  rc_result_t expected_rc[$];
  int         mismatch_count = 0;
  int         items_queued = 0;
  bit         steady_flow = 1'b0;   // no gaps and no stalls while set
  width_t     last_edge_time = '0;

  // ---------------------------------------------------------------------------
  // Local decoder: registers and state, kept in step with accepted items
  // ---------------------------------------------------------------------------
  width_t     dec_sync_min = SYNC_MIN_RST;
  width_t     dec_center_yaw = CENTER_RST;
  width_t     dec_center_pitch = CENTER_RST;
  width_t     dec_center_roll = CENTER_RST;
  width_t     dec_hold = HOLD_RST;

  logic [1:0] dec_phase = PH_SYNC_START;
  logic       dec_expect_rising = 1'b1;
  width_t     dec_ref_time = '0;
  logic [2:0] dec_chan_idx = '0;
  chan_arr_t  dec_widths = {NUM_CH{CHAN_RST}};
  logic [7:0] dec_prev_code = CODE_RESTART;
  width_t     dec_lock_count = '0;
  width_t     dec_unlock_count = '0;
  logic       dec_lock_flag = 1'b1;

  // stick position to zone: low, centre band, high, or none
  function automatic logic [1:0] stick_zone(input width_t w);
    if (w < ZONE_LOW) return ZONE_LO;
    if (w > ZONE_HIGH) return ZONE_HI;
    if (w > ZONE_MID_LO && w < ZONE_MID_HI) return ZONE_MID;
    return ZONE_NONE;
  endfunction

  function automatic rc_result_t decode_event(input logic kind, input width_t stamp,
                                              input logic rising);
    rc_result_t res;
    logic       done;
    width_t     span;
    logic [7:0] code;
    done = 1'b0;
    if (kind == KIND_EDGE) begin
      // edges of the other polarity pass through untouched
      if (rising == dec_expect_rising) begin
        case (dec_phase)
          PH_SYNC_START: begin
            dec_ref_time = stamp;
            dec_expect_rising = 1'b0;
            dec_phase = PH_SYNC_END;
          end
          PH_SYNC_END: begin
            span = stamp - dec_ref_time;
            dec_ref_time = stamp;
            dec_expect_rising = 1'b1;
            dec_phase = (span < dec_sync_min) ? PH_SYNC_START : PH_CHAN_END;
          end
          PH_CHAN_END: begin
            if (dec_chan_idx >= NUM_CH) dec_chan_idx = '0;
            dec_widths[dec_chan_idx] = stamp - dec_ref_time;
            dec_expect_rising = 1'b0;
            dec_phase = PH_CHAN_START;
            dec_chan_idx = dec_chan_idx + 3'd1;
            if (dec_chan_idx >= NUM_CH) begin
              dec_chan_idx = '0;
              dec_phase = PH_SYNC_START;
              done = 1'b1;
            end
          end
          default: begin
            dec_ref_time = stamp;
            dec_expect_rising = 1'b1;
            dec_phase = PH_CHAN_END;
          end
        endcase
      end
    end else begin
      code = {stick_zone(dec_widths[0]), stick_zone(dec_widths[1]),
              stick_zone(dec_widths[2]), stick_zone(dec_widths[3])};
      // a new gesture restarts both hold counters
      if (code != dec_prev_code) begin
        dec_prev_code = code;
        code = CODE_RESTART;
      end
      case (code)
        CODE_LOCK:   dec_lock_count = dec_lock_count + 16'd1;
        CODE_UNLOCK: dec_unlock_count = dec_unlock_count + 16'd1;
        CODE_KEEP_A, CODE_KEEP_B, CODE_KEEP_C,
        CODE_KEEP_D, CODE_KEEP_E, CODE_KEEP_F: ;
        default: begin
          dec_lock_count = '0;
          dec_unlock_count = '0;
        end
      endcase
      if (dec_lock_count >= dec_hold) begin
        dec_lock_count = '0;
        dec_lock_flag = 1'b1;
      end else if (dec_unlock_count >= dec_hold) begin
        dec_unlock_count = '0;
        dec_lock_flag = 1'b0;
      end
    end
    res.yaw          = width_t'(dec_widths[0] - dec_center_yaw + CENTER_OFFSET);
    res.pitch        = width_t'(dec_widths[1] - dec_center_pitch + CENTER_OFFSET);
    res.altitude     = dec_widths[2];
    res.roll         = width_t'(dec_widths[3] - dec_center_roll + CENTER_OFFSET);
    res.gate         = dec_widths[4];
    res.rate         = dec_widths[5];
    res.frame_done   = done;
    res.sticks_ready = (dec_widths[2] < STICK_LOW) && (dec_widths[3] < STICK_LOW);
    res.locked       = dec_lock_flag;
    return res;
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int pick_pause();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one item per handshake, random gaps between items
  // ---------------------------------------------------------------------------
  int src_gap = 0;

  always @(posedge clk) begin : drive_items
    ppm_event_t ev;
    logic       free;
    logic       pol;
    width_t     stamp;
    width_t     delta;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= KIND_EDGE;
      src_gap = 0;
    end else begin
      free = !in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_rc.push_back(decode_event(in_tuser, in_tdata[15:0], in_tdata[16]));
        free = 1'b1;
      end
      if (free) begin
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
          in_tvalid <= 1'b0;
        end else if (queued_events.size() > 0) begin
          ev = queued_events.pop_front();
          stamp = ev.stamp;
          pol = ev.rising;
          // the decoder state is current here: the item just accepted is in it
          if (ev.kind == KIND_EDGE && ev.tracking) begin
            pol = dec_expect_rising;
            case (dec_phase)
              PH_SYNC_END:   delta = ev.sync_w;
              PH_CHAN_END:   delta = ev.widths[(dec_chan_idx < NUM_CH) ? dec_chan_idx : 3'd0];
              PH_CHAN_START: delta = ev.gap_w;
              default:       delta = ev.stamp;
            endcase
            stamp = last_edge_time + delta;
          end
          if (ev.kind == KIND_EDGE) last_edge_time = stamp;
          in_tvalid <= 1'b1;
          in_tuser  <= ev.kind;
          in_tdata  <= {7'b0, pol, stamp};
          src_gap = (!steady_flow && $urandom_range(0, 99) < 30) ? pick_pause() : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random back-pressure, field by field comparison
  // ---------------------------------------------------------------------------
  int sink_stall = 0;

  task automatic check_field(input string name, input width_t want, input width_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    rc_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_rc.size() == 0) begin
          $error("result item with nothing expected");
          mismatch_count++;
        end else begin
          want = expected_rc.pop_front();
          check_field("rc_yaw", want.yaw, out_tdata[15:0]);
          check_field("rc_pitch", want.pitch, out_tdata[31:16]);
          check_field("rc_altitude", want.altitude, out_tdata[47:32]);
          check_field("rc_roll", want.roll, out_tdata[63:48]);
          check_field("rc_gate", want.gate, out_tdata[79:64]);
          check_field("rc_rate", want.rate, out_tdata[95:80]);
          check_field("frame_done", want.frame_done, out_tlast);
          check_field("sticks_ready", want.sticks_ready, out_tdata[96]);
          check_field("locked", want.locked, out_tdata[97]);
        end
      end
      if (sink_stall > 0) begin
        sink_stall = sink_stall - 1;
        out_tready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 99) < 20) begin
        sink_stall = pick_pause() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_edge(input width_t stamp, input logic rising);
    ppm_event_t ev;
    ev = '{kind: KIND_EDGE, tracking: 1'b0, stamp: stamp, rising: rising,
           sync_w: '0, gap_w: '0, widths: '0};
    queued_events.push_back(ev);
    items_queued++;
  endtask

  // tick items carry random, unused time and polarity bits
  task automatic add_ticks(input int n);
    ppm_event_t ev;
    repeat (n) begin
      ev = '{kind: KIND_TICK, tracking: 1'b0, stamp: width_t'($urandom),
             rising: 1'($urandom), sync_w: '0, gap_w: '0, widths: '0};
      queued_events.push_back(ev);
      items_queued++;
    end
  endtask

  // a full frame is 13 accepted edges: sync start, sync end, six widths with
  // five channel starts between them; fewer edges leave a broken frame
  task automatic add_frame(input width_t sync_w, input chan_arr_t w, input int n_edges);
    ppm_event_t ev;
    repeat (n_edges) begin
      ev = '{kind: KIND_EDGE, tracking: 1'b1, stamp: width_t'($urandom_range(100, 3000)),
             rising: 1'b0, sync_w: sync_w, gap_w: width_t'($urandom_range(200, 600)),
             widths: w};
      queued_events.push_back(ev);
      items_queued++;
    end
  endtask

  function automatic width_t width_in_zone(input logic [1:0] z);
    case (z)
      ZONE_LO:  return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1149)
                                                   : $urandom_range(950, 1149);
      ZONE_MID: return $urandom_range(1351, 1649);
      ZONE_HI:  return ($urandom_range(0, 9) == 0) ? $urandom_range(1851, 65535)
                                                   : $urandom_range(1851, 2100);
      default:  return $urandom_range(0, 1) ? $urandom_range(1150, 1350)
                                            : $urandom_range(1650, 1850);
    endcase
  endfunction

  function automatic width_t any_width();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 65535);
    return $urandom_range(900, 2100);
  endfunction

  // sync interval: mostly long enough, sometimes below the minimum
  function automatic width_t pick_sync();
    int hi;
    if (dec_sync_min > 0 && $urandom_range(0, 99) < 15)
      return $urandom_range(0, dec_sync_min - 1);
    hi = int'(dec_sync_min) + 3000;
    if (hi > 65535) hi = 65535;
    return $urandom_range(dec_sync_min, hi);
  endfunction

  function automatic logic [7:0] pick_gesture();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CODE_LOCK;
    if (r < 60) return CODE_UNLOCK;
    if (r < 80) begin
      case ($urandom_range(0, 5))
        0: return CODE_KEEP_A;
        1: return CODE_KEEP_B;
        2: return CODE_KEEP_C;
        3: return CODE_KEEP_D;
        4: return CODE_KEEP_E;
        default: return CODE_KEEP_F;
      endcase
    end
    return 8'($urandom);
  endfunction

  // one random burst: mostly a gesture frame followed by a run of ticks
  task automatic add_burst();
    int         r;
    int         i;
    int         n;
    chan_arr_t  w;
    logic [7:0] code;
    r = $urandom_range(0, 99);
    for (i = 0; i < NUM_CH; i++) w[i] = any_width();
    if (r < 55) begin
      code = pick_gesture();
      w[0] = width_in_zone(code[7:6]);
      w[1] = width_in_zone(code[5:4]);
      w[2] = width_in_zone(code[3:2]);
      w[3] = width_in_zone(code[1:0]);
      add_frame(pick_sync(), w, 13);
      n = (dec_hold <= 30) ? $urandom_range(1, int'(dec_hold) + 3) : $urandom_range(1, 30);
      add_ticks(n);
    end else if (r < 70) begin
      add_frame(pick_sync(), w, 13);
    end else if (r < 80) begin
      // frame cut short, then stray edges
      add_frame(pick_sync(), w, $urandom_range(1, 12));
      repeat ($urandom_range(1, 2)) add_edge(width_t'($urandom), 1'($urandom));
    end else if (r < 90) begin
      repeat ($urandom_range(1, 5)) add_edge(width_t'($urandom), 1'($urandom));
    end else begin
      add_ticks($urandom_range(1, 5));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input width_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SYNC_MIN:     dec_sync_min = val;
      REG_CENTER_YAW:   dec_center_yaw = val;
      REG_CENTER_PITCH: dec_center_pitch = val;
      REG_CENTER_ROLL:  dec_center_roll = val;
      REG_HOLD_TICKS:   dec_hold = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_registers(input width_t sync_min, input width_t yaw, input width_t pitch,
                               input width_t roll, input width_t hold);
    write_reg(REG_SYNC_MIN, sync_min);
    write_reg(REG_CENTER_YAW, yaw);
    write_reg(REG_CENTER_PITCH, pitch);
    write_reg(REG_CENTER_ROLL, roll);
    write_reg(REG_HOLD_TICKS, hold);
  endtask

  // everything sent and answered, and the two-stage pipe left to settle
  task automatic wait_drained();
    do @(posedge clk);
    while (queued_events.size() != 0 || in_tvalid || expected_rc.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_random(input int n_items);
    int target;
    target = items_queued + n_items;
    while (items_queued < target) add_burst();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    chan_arr_t w;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed, at reset register values
    add_ticks(1);                          // tick on reset widths
    add_edge(16'h1234, 1'b0);              // falling while rising expected: ignored
    add_edge(16'hFFFF, 1'b1);              // sync start at top of timer
    add_edge(16'h0000, 1'b1);              // wrong polarity again
    add_edge(16'h0100, 1'b0);              // sync too short, across the wrap
    // widths 0, 65535 and values at the zone thresholds; sync exactly at minimum
    w = {16'd1850, 16'd1350, 16'd1150, 16'd1149, 16'hFFFF, 16'd0};
    add_frame(16'd2500, w, 13);
    add_edge(16'hAAAA, 1'b1);              // after a frame a falling edge is expected
    add_frame(16'd2499, w, 2);             // sync one tick short
    add_ticks(3);
    wait_drained();

    // register extremes and a spread of settings
    set_registers(16'd0, 16'd0, 16'hFFFF, CENTER_RST, 16'd1);
    run_random(320);

    set_registers(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    run_random(320);

    steady_flow = 1'b1;
    set_registers($urandom_range(1000, 4000), $urandom, $urandom, $urandom, 16'd3);
    run_random(320);
    steady_flow = 1'b0;

    set_registers(SYNC_MIN_RST, CENTER_RST, CENTER_RST, CENTER_RST, 16'd2);
    run_random(320);

    set_registers($urandom_range(0, 65535), $urandom, $urandom, $urandom, 16'd5);
    run_random(320);

    // writes to unused indexes must change nothing; hold of zero locks on every tick
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    write_reg(REG_SPARE_C, $urandom);
    set_registers(SYNC_MIN_RST, $urandom, $urandom, $urandom, 16'd0);
    run_random(320);

    if (mismatch_count == 0) begin
      $display("PASS ppm_receiver_with_arm_gesture");
    end else begin
      $display("FAIL ppm_receiver_with_arm_gesture");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("FAIL ppm_receiver_with_arm_gesture");
    $finish;
  end

endmodule
